### rtl/core/m4i_pkg.sv
package m4i_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int WORD_WIDTH_DEF = 32;

	// multiplicand source
	localparam logic [1:0] MC_ELEM = 2'd0;
	localparam logic [1:0] MC_MNR  = 2'd1;
	localparam logic [1:0] MC_COF  = 2'd2;

	// accumulator that a finished product goes into
	localparam logic [1:0] TGT_MNR = 2'd0;
	localparam logic [1:0] TGT_COF = 2'd1;
	localparam logic [1:0] TGT_DET = 2'd2;

	typedef struct packed {
		logic       wr_en;
		logic [3:0] wr_addr;
		logic [3:0] rd_addr;
		logic [1:0] mc_src;
		logic       mc_load;
		logic       ld_mplier;
		logic       mul_step;
		logic       mul_last;
		logic       cmt_en;
		logic [1:0] cmt_tgt;
		logic       cmt_clr;
		logic       cmt_sub;
		logic       div_init;
		logic       div_chk;
		logic       div_step;
		logic       out_load;
		logic       out_last;
	} m4i_cmd_t;

	typedef struct packed {
		logic det_zero;
	} m4i_stat_t;

endpackage

### rtl/core/m4i_ctrl.sv
module m4i_ctrl #(
	parameter int WORD_WIDTH = m4i_pkg::WORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output m4i_pkg::m4i_cmd_t  cmd,
	input  m4i_pkg::m4i_stat_t stat
);
	import m4i_pkg::*;

	localparam int CW = $clog2(WORD_WIDTH);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_RDA  = 4'd1;
	localparam logic [3:0] ST_RDB  = 4'd2;
	localparam logic [3:0] ST_LDM  = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_CMT  = 4'd5;
	localparam logic [3:0] ST_DIV0 = 4'd6;
	localparam logic [3:0] ST_DIV1 = 4'd7;
	localparam logic [3:0] ST_DIVI = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]    state_q;
	logic [3:0]    load_cnt_q;
	logic [3:0]    kk_q;
	logic [1:0]    ti_q;
	logic [1:0]    pi_q;
	logic          dmode_q;
	logic          dp_q;
	logic          ov_q;
	logic [CW-1:0] cnt_q;

	logic       cnt_last;
	logic       accept;
	logic [1:0] ri, cj;
	logic [1:0] r0, r1, r2, c0, c1, c2, ca, cb, ct;
	logic       par;
	logic [3:0] addr_a, addr_b;

	// index n of three, skipping row or column x
	function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] x);
		logic [1:0] r;
		r = (n >= x) ? n + 2'd1 : n;
		return r;
	endfunction

	assign cnt_last = (cnt_q == CW'(WORD_WIDTH - 1));
	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;
	assign out_valid = ov_q;

	assign ri  = dmode_q ? 2'd0 : kk_q[3:2];
	assign cj  = kk_q[1:0];
	assign r0  = skip(2'd0, ri);
	assign r1  = skip(2'd1, ri);
	assign r2  = skip(2'd2, ri);
	assign c0  = skip(2'd0, cj);
	assign c1  = skip(2'd1, cj);
	assign c2  = skip(2'd2, cj);
	assign ca  = (ti_q == 2'd0) ? c1 : c0;
	assign cb  = (ti_q == 2'd2) ? c1 : c2;
	assign ct  = (ti_q == 2'd0) ? c0 : ((ti_q == 2'd1) ? c1 : c2);
	assign par = ri[0] ^ cj[0];

	// address is column * 4 + row
	always_comb begin
		addr_a = (pi_q == 2'd0) ? {ca, r1} : {cb, r1};
		if (dp_q) begin
			addr_b = {cj, 2'd0};
		end else if (pi_q == 2'd0) begin
			addr_b = {cb, r2};
		end else if (pi_q == 2'd1) begin
			addr_b = {ca, r2};
		end else begin
			addr_b = {ct, r0};
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.wr_en     = accept;
		cmd.wr_addr   = load_cnt_q;
		cmd.rd_addr   = (state_q == ST_RDA) ? addr_a : addr_b;
		cmd.mc_src    = dp_q ? MC_COF : ((pi_q == 2'd2) ? MC_MNR : MC_ELEM);
		cmd.mc_load   = (state_q == ST_RDB);
		cmd.ld_mplier = (state_q == ST_LDM);
		cmd.mul_step  = (state_q == ST_MUL);
		cmd.mul_last  = cnt_last;
		cmd.cmt_en    = (state_q == ST_CMT);
		if (dp_q) begin
			cmd.cmt_tgt = TGT_DET;
			cmd.cmt_clr = (cj == 2'd0);
			cmd.cmt_sub = 1'b0;
		end else if (pi_q == 2'd2) begin
			cmd.cmt_tgt = TGT_COF;
			cmd.cmt_clr = (ti_q == 2'd0);
			cmd.cmt_sub = (ti_q == 2'd1) ^ par;
		end else begin
			cmd.cmt_tgt = TGT_MNR;
			cmd.cmt_clr = (pi_q == 2'd0);
			cmd.cmt_sub = (pi_q == 2'd1);
		end
		cmd.div_init = (state_q == ST_DIV0);
		cmd.div_chk  = (state_q == ST_DIV1);
		cmd.div_step = (state_q == ST_DIVI);
		cmd.out_load = (state_q == ST_OUT) && (!ov_q || out_ready);
		cmd.out_last = (kk_q == 4'd15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			kk_q       <= '0;
			ti_q       <= '0;
			pi_q       <= '0;
			dmode_q    <= 1'b0;
			dp_q       <= 1'b0;
			ov_q       <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						load_cnt_q <= load_cnt_q + 4'd1;
						if (load_cnt_q == 4'd15) begin
							dmode_q <= 1'b1;
							dp_q    <= 1'b0;
							kk_q    <= '0;
							ti_q    <= '0;
							pi_q    <= '0;
							state_q <= ST_RDA;
						end
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_LDM;
				ST_LDM: begin
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_last) begin
						state_q <= ST_CMT;
					end
				end
				ST_CMT: begin
					if (dp_q) begin
						dp_q <= 1'b0;
						ti_q <= '0;
						pi_q <= '0;
						if (kk_q == 4'd3) begin
							dmode_q <= 1'b0;
							kk_q    <= '0;
						end else begin
							kk_q <= kk_q + 4'd1;
						end
						state_q <= ST_RDA;
					end else if (pi_q != 2'd2) begin
						pi_q    <= pi_q + 2'd1;
						state_q <= ST_RDA;
					end else if (ti_q != 2'd2) begin
						ti_q    <= ti_q + 2'd1;
						pi_q    <= '0;
						state_q <= ST_RDA;
					end else if (dmode_q) begin
						dp_q    <= 1'b1;
						state_q <= ST_RDA;
					end else begin
						state_q <= stat.det_zero ? ST_OUT : ST_DIV0;
					end
				end
				ST_DIV0: state_q <= ST_DIV1;
				ST_DIV1: begin
					cnt_q   <= '0;
					state_q <= ST_DIVI;
				end
				ST_DIVI: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (cmd.out_load) begin
						ti_q <= '0;
						pi_q <= '0;
						if (kk_q == 4'd15) begin
							state_q <= ST_LOAD;
						end else begin
							kk_q    <= kk_q + 4'd1;
							state_q <= ST_RDA;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

### rtl/core/m4i_dpath.sv
module m4i_dpath #(
	parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = m4i_pkg::WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  m4i_pkg::m4i_cmd_t     cmd,
	output m4i_pkg::m4i_stat_t    stat,
	input  logic [WORD_WIDTH-1:0] in_value,
	output logic [WORD_WIDTH-1:0] out_value,
	output logic                  out_singular,
	output logic                  out_overflow,
	output logic                  out_last
);
	import m4i_pkg::*;

	localparam int W  = WORD_WIDTH;
	localparam int AW = 4 * W + 4;
	localparam int NW = 5 * W + 2 * FRAC_BITS + 4;
	localparam logic [W-1:0] HALF = {1'b1, {(W - 1){1'b0}}};

	logic [W-1:0]  mem_q [16];
	logic [W-1:0]  rd_q;
	logic [AW-1:0] mcand_q, prod_q, mnr_q, cof_q, det_q;
	logic [W-1:0]  mplier_q;
	logic [NW-1:0] num_q, dvs_q;
	logic [W-1:0]  quo_q;
	logic          neg_q, ovf_q;

	logic [AW-1:0] rd_ext, tgt_val, cmt_val, abs_cof, abs_det;
	logic [W-1:0]  q_sat, q_res;
	logic          sat;
	logic          num_ge;

	assign rd_ext  = {{(AW - W){rd_q[W-1]}}, rd_q};
	assign abs_cof = cof_q[AW-1] ? -cof_q : cof_q;
	assign abs_det = det_q[AW-1] ? -det_q : det_q;
	assign num_ge  = (num_q >= dvs_q);
	assign stat.det_zero = (det_q == '0);

	always_comb begin
		unique case (cmd.cmt_tgt)
			TGT_MNR: tgt_val = mnr_q;
			TGT_COF: tgt_val = cof_q;
			default: tgt_val = det_q;
		endcase
		cmt_val = (cmd.cmt_clr ? '0 : tgt_val) + (cmd.cmt_sub ? -prod_q : prod_q);
	end

	// saturate the magnitude, then apply the sign
	always_comb begin
		sat   = ovf_q || (neg_q ? (quo_q > HALF) : (quo_q > HALF - W'(1)));
		q_sat = sat ? (neg_q ? HALF : HALF - W'(1)) : quo_q;
		q_res = neg_q ? -q_sat : q_sat;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= in_value;
		end
		rd_q <= mem_q[cmd.rd_addr];

		if (cmd.mc_load) begin
			unique case (cmd.mc_src)
				MC_MNR:  mcand_q <= mnr_q;
				MC_COF:  mcand_q <= cof_q;
				default: mcand_q <= rd_ext;
			endcase
		end
		if (cmd.ld_mplier) begin
			mplier_q <= rd_q;
			prod_q   <= '0;
		end
		// shift-add, the sign bit has negative weight
		if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + (cmd.mul_last ? -mcand_q : mcand_q);
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.cmt_en) begin
			unique case (cmd.cmt_tgt)
				TGT_MNR: mnr_q <= cmt_val;
				TGT_COF: cof_q <= cmt_val;
				default: det_q <= cmt_val;
			endcase
		end

		// round to nearest: (2*|cof|*2^2F + |det|) / (2*|det|)
		if (cmd.div_init) begin
			neg_q <= cof_q[AW-1] ^ det_q[AW-1];
			num_q <= (NW'(abs_cof) << (2 * FRAC_BITS + 1)) + NW'(abs_det);
			dvs_q <= NW'(abs_det) << (W + 1);
		end
		if (cmd.div_chk) begin
			ovf_q <= num_ge;
			dvs_q <= dvs_q >> 1;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (num_ge) begin
				num_q <= num_q - dvs_q;
			end
			quo_q <= {quo_q[W-2:0], num_ge};
			dvs_q <= dvs_q >> 1;
		end

		if (cmd.out_load) begin
			out_value    <= stat.det_zero ? '0 : q_res;
			out_singular <= stat.det_zero;
			out_overflow <= !stat.det_zero && sat;
			out_last     <= cmd.out_last;
		end
	end

endmodule

### rtl/core/matrix4_inverse.sv
// 4x4 matrix inverse, signed fixed point with FRAC_BITS fraction bits in a WORD_WIDTH word.
// sixteen elements come in column-major order, one request each; the sixteenth starts the
// work and the block then sends sixteen inverse elements, also column-major, with tlast on
// the sixteenth. the determinant and cofactors are exact and every element is rounded once
// to nearest, ties away from zero. a zero determinant gives zero elements with singular set;
// an element beyond the word range saturates and sets overflow. all arithmetic runs on one
// bit-serial shift-add multiplier and one restoring divider. the determinant takes 40
// products and each output element 9 products plus one division. input is taken only
// while elements are being loaded; the last result may still wait on the output register
// while the next matrix loads.
module matrix4_inverse #(
	parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = m4i_pkg::WORD_WIDTH_DEF,
	parameter int DW         = ((WORD_WIDTH + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // element_value
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata,   // inverse_value
	output logic [1:0]    m_tuser,   // singular, overflow
	output logic          m_tlast
);
	import m4i_pkg::*;

	m4i_cmd_t              cmd;
	m4i_stat_t             stat;
	logic [WORD_WIDTH-1:0] value;

	m4i_ctrl #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	m4i_dpath #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_WIDTH(WORD_WIDTH)
	) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.in_value     (s_tdata[WORD_WIDTH-1:0]),
		.out_value    (value),
		.out_singular (m_tuser[0]),
		.out_overflow (m_tuser[1]),
		.out_last     (m_tlast)
	);

	// zero fill up to whole bytes
	assign m_tdata = DW'(value);

endmodule

### rtl/core/m4i_checker.sv
module m4i_checker #(
	parameter int DW = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata,
	input logic [1:0]    m_tuser,
	input logic          m_tlast
);

	// a waiting request keeps its valid
	a_hold_in_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid)
		else $error("request dropped while waiting");

	// a stalled result keeps its valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// singular results are zero and never saturated
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
		else $error("singular result not clean");

	// nothing follows the last result until a new matrix is loaded
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result after end of run");

endmodule

bind matrix4_inverse m4i_checker #(.DW(DW)) u_m4i_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### tb/sv/tb_matrix4_inverse.sv
module tb_matrix4_inverse;
	import m4i_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int WW = WORD_WIDTH_DEF;
	localparam int MATRICES = 16;
	localparam int CYCLE_LIMIT = 1500000;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [31:0] value;
		logic        singular;
		logic        overflow;
		logic        last;
	} inv_elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	logic [31:0]       element_queue[$];
	inv_elem_t         inverse_queue[$];
	logic signed [31:0] loaded[16];
	int unsigned       load_idx = 0;
	int unsigned       errors = 0;
	int unsigned       cycles = 0;
	int unsigned       in_gap = 0;
	int unsigned       out_gap = 0;
	logic              in_fire = 1'b0;
	logic              out_fire = 1'b0;

	matrix4_inverse dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic wide_t elem_at(int r, int c);
		wide_t w;
		w = loaded[(r & 3) + 4 * (c & 3)];
		return w;
	endfunction

	// signed 3x3 minor of the stored matrix without row i and column j
	function automatic wide_t cofactor_of(int i, int j);
		int    rs[3];
		int    cs[3];
		int    n;
		wide_t t0, t1, t2, s;
		n = 0;
		for (int k = 0; k < 4; k++) if (k != i) begin rs[n] = k; n++; end
		n = 0;
		for (int k = 0; k < 4; k++) if (k != j) begin cs[n] = k; n++; end
		t0 = elem_at(rs[1], cs[1]) * elem_at(rs[2], cs[2])
			- elem_at(rs[1], cs[2]) * elem_at(rs[2], cs[1]);
		t1 = elem_at(rs[1], cs[0]) * elem_at(rs[2], cs[2])
			- elem_at(rs[1], cs[2]) * elem_at(rs[2], cs[0]);
		t2 = elem_at(rs[1], cs[0]) * elem_at(rs[2], cs[1])
			- elem_at(rs[1], cs[1]) * elem_at(rs[2], cs[0]);
		s = elem_at(rs[0], cs[0]) * t0 - elem_at(rs[0], cs[1]) * t1
			+ elem_at(rs[0], cs[2]) * t2;
		return ((i + j) & 1) ? -s : s;
	endfunction

	// inverse of the stored matrix, rounded half away from zero and saturated
	task automatic predict_inverse();
		wide_t       det, cof;
		logic [255:0] n, d, q, lim;
		logic        neg;
		inv_elem_t   e;
		det = '0;
		for (int j = 0; j < 4; j++) det += elem_at(0, j) * cofactor_of(0, j);
		for (int k = 0; k < 16; k++) begin
			e.value = '0;
			e.singular = (det == 0);
			e.overflow = 1'b0;
			e.last = (k == 15);
			if (!e.singular) begin
				cof = cofactor_of(k >> 2, k & 3);
				neg = (cof < 0) != (det < 0);
				n = (cof < 0) ? -cof : cof;
				d = (det < 0) ? -det : det;
				q = ((n << (2 * FB + 1)) + d) / (d << 1);
				lim = neg ? (256'd1 << (WW - 1)) : ((256'd1 << (WW - 1)) - 1);
				if (q > lim) begin
					q = lim;
					e.overflow = 1'b1;
				end
				if (neg) q = -q;
				e.value = q[31:0];
			end
			inverse_queue.push_back(e);
		end
	endtask

	// posedge: accept requests, predict on the sixteenth, check results
	always @(posedge clk) begin
		inv_elem_t e;
		cycles <= cycles + 1;
		in_fire <= s_tvalid && s_tready;
		out_fire <= m_tvalid && m_tready;
		if (arst_n && s_tvalid && s_tready) begin
			loaded[load_idx] = s_tdata;
			if (load_idx == 15) begin
				load_idx = 0;
				predict_inverse();
			end else begin
				load_idx++;
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (inverse_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result data=%h user=%b last=%b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				e = inverse_queue.pop_front();
				if (m_tdata !== e.value || m_tuser[0] !== e.singular ||
					m_tuser[1] !== e.overflow || m_tlast !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp data=%h sing=%b ovf=%b last=%b got data=%h sing=%b ovf=%b last=%b",
							e.value, e.singular, e.overflow, e.last,
							m_tdata, m_tuser[0], m_tuser[1], m_tlast);
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_matrix4_inverse: FAIL");
			$finish;
		end
	end

	// driver: one request at a time with random gaps, bursts without gaps
	always @(negedge clk) begin
		logic v;
		logic r;
		if (arst_n) begin
			v = s_tvalid;
			if (in_fire) v = 1'b0;
			if (!v) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (element_queue.size() > 0) begin
					s_tdata <= element_queue.pop_front();
					v = 1'b1;
					in_gap = cycles[10] ? 0 : $urandom_range(0, 19);
				end
			end
			s_tvalid <= v;

			// receiver stalls
			r = m_tready;
			if (out_fire) begin
				r = 1'b0;
				out_gap = cycles[9] ? 0 : $urandom_range(0, 19);
			end
			if (!r) begin
				if (out_gap > 0) out_gap--;
				else r = 1'b1;
			end
			m_tready <= r;
		end
	end

	function automatic logic [31:0] rand_elem(int kind, int k);
		logic [31:0] v;
		case (kind)
			0: v = $urandom;
			1: v = ((k % 5) == 0 ? 32'h0001_0000 : 32'h0) + $urandom_range(0, 32767) - 16384;
			2: v = $urandom_range(0, 510) - 255;
			default: v = ($urandom_range(0, 8) - 4) << FB;
		endcase
		return v;
	endfunction

	initial begin
		logic [31:0] m[16];
		int          kind;
		// diagonal extremes: +1 and -1 raw saturate, full-scale values invert without saturating
		for (int k = 0; k < 16; k++) m[k] = '0;
		m[0] = 32'h0000_0001;
		m[5] = 32'hFFFF_FFFF;
		m[10] = 32'h7FFF_FFFF;
		m[15] = 32'h8000_0000;
		for (int k = 0; k < 16; k++) element_queue.push_back(m[k]);
		for (int i = 1; i < MATRICES; i++) begin
			kind = $urandom_range(0, 4);
			for (int k = 0; k < 16; k++) m[k] = rand_elem(kind == 4 ? 0 : kind, k);
			// singular: repeat a column, or zero everything now and then
			if (kind == 4 || $urandom_range(0, 5) == 0) begin
				for (int r = 0; r < 4; r++) m[12 + r] = m[r];
				if ($urandom_range(0, 3) == 0) for (int k = 0; k < 16; k++) m[k] = '0;
			end
			for (int k = 0; k < 16; k++) element_queue.push_back(m[k]);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (element_queue.size() == 0 && !s_tvalid);
		wait (inverse_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("tb_matrix4_inverse: PASS");
		end else begin
			$display("tb_matrix4_inverse: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/m4i_pkg.sv
rtl/core/m4i_ctrl.sv
rtl/core/m4i_dpath.sv
rtl/core/matrix4_inverse.sv
rtl/core/m4i_checker.sv
tb/sv/tb_matrix4_inverse.sv
